FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the matcher modules. Clock and reset names
// are fixed to i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define WW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define WW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wwpm_pkg.sv
// ----------------------------------------------------------------------------
// wwpm_pkg
// Types, constants and helpers for the whole-word pattern matcher.
// ----------------------------------------------------------------------------
package wwpm_pkg;

    localparam int PATTERN_MAX  = 32;
    localparam int WIN_DEPTH    = PATTERN_MAX + 1;
    localparam int SENTENCE_MAX = 4096;
    localparam int POS_W        = 12;
    localparam int LEN_W        = 6;
    localparam int PIDX_W       = $clog2(PATTERN_MAX);
    localparam int WIDX_W       = $clog2(WIN_DEPTH);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [7:0] SPACE_CODE = 8'd32;

    // Offset counter stops at the smaller of the sentence bound and the field top.
    localparam int POS_LIMIT_I = (SENTENCE_MAX - 1 > 4095) ? 4095 : SENTENCE_MAX - 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW    = 3'd0,
        CFG_PAT_SECOND = 3'd1,
        CFG_PAT_THIRD  = 3'd2,
        CFG_PAT_HIGH   = 3'd3,
        CFG_PAT_LEN    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [15:0] in_book;
        logic [15:0] in_page;
        logic [15:0] in_paragraph;
        logic [15:0] in_sentence;
        logic        sentence_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_book;
        logic [15:0] out_page;
        logic [15:0] out_paragraph;
        logic [15:0] out_sentence;
        logic [11:0] start_offset;
        logic [31:0] match_total;
        logic        last_of_run;
    } t_out_item;

    // Pattern right-aligned to the window: chars[j] is compared with window[j].
    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] chars;
        logic [PATTERN_MAX-1:0]      use_mask;
        logic [LEN_W-1:0]            len;
    } t_pat_cfg;

    // Results produced by one transaction, first in stream order.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  first;
        t_out_item  second;
    } t_push;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c inside {[8'd65:8'd90]}) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

FILE: design/whole_word_pattern_matcher.sv
// ----------------------------------------------------------------------------
// whole_word_pattern_matcher
// Streams sentence characters and reports whole-word pattern occurrences.
// ----------------------------------------------------------------------------
// The block takes one character transaction per clock while o_in_ready is
// high. A character sits in the input register, is folded to lower case and
// shifted into a 33-entry window, and all 32 pattern positions are compared
// at once against the registered, pre-aligned pattern; results go into a
// four-entry queue that offers them for reading, and a queue short of room
// holds the character in the input register. A match that ends mid-sentence
// is held until the next character shows whether a space follows; a
// sentence-end character can thus yield two results, delivered one after the
// other. Input throughput is one character per cycle, set by the single-pass
// window compare; o_in_ready drops only while three or more results wait in
// the output queue. Pattern registers must be written through the plain write
// port only while the stream is idle; the block does not enforce this. A new
// pattern takes effect for characters accepted after the write.
// ----------------------------------------------------------------------------
module whole_word_pattern_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [wwpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wwpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // character stream
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wwpm_pkg::t_in_item                i_in_item,
    // match reports
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wwpm_pkg::t_out_item               o_out_item
);
    import wwpm_pkg::*;

    t_pat_cfg  pat;
    t_push     push;
    logic      room;

    // Pattern registers; the aligned copy is registered so the compare path
    // starts at flops.
    wwpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pat      (pat)
    );

    // Window, offset counter, pending match and running total.
    wwpm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_pat      (pat),
        .i_room     (room),
        .o_push     (push)
    );

    // Result queue decouples the report side from the character stream.
    wwpm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: design/wwpm_cfg.sv
// ----------------------------------------------------------------------------
// wwpm_cfg
// Pattern registers and the registered, case-folded, window-aligned pattern.
// ----------------------------------------------------------------------------
module wwpm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wwpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wwpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output wwpm_pkg::t_pat_cfg                o_pat
);
    import wwpm_pkg::*;

    logic [PATTERN_MAX-1:0][7:0] r_pat;
    logic [LEN_W-1:0]            r_len;
    t_pat_cfg                    r_align;
    t_pat_cfg                    n_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LOW:    r_pat[7:0]   <= i_cfg_data;
                CFG_PAT_SECOND: r_pat[15:8]  <= i_cfg_data;
                CFG_PAT_THIRD:  r_pat[23:16] <= i_cfg_data;
                CFG_PAT_HIGH:   r_pat[31:24] <= i_cfg_data;
                CFG_PAT_LEN:    r_len        <= i_cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Lengths above PATTERN_MAX act as the full pattern; char k lands on
    // window tap len-1-k.
    always_comb begin
        logic [LEN_W-1:0] len_eff;
        logic [LEN_W-1:0] k;
        len_eff = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_len;
        n_align.len = len_eff;
        k = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (LEN_W'(j) < len_eff) begin
                k = len_eff - LEN_W'(j) - LEN_W'(1);
                n_align.chars[j]    = fold_case(r_pat[k[PIDX_W-1:0]]);
                n_align.use_mask[j] = 1'b1;
            end else begin
                n_align.chars[j]    = 8'd0;
                n_align.use_mask[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_align <= n_align;
    end

    assign o_pat = r_align;

endmodule

FILE: design/wwpm_core.sv
// ----------------------------------------------------------------------------
// wwpm_core
// Input register, character window and single-pass whole-word compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wwpm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wwpm_pkg::t_in_item  i_in_item,
    input  wwpm_pkg::t_pat_cfg  i_pat,
    input  logic                i_room,
    output wwpm_pkg::t_push     o_push
);
    import wwpm_pkg::*;

    logic                         r_in_vld;
    t_in_item                     r_in;
    logic [WIN_DEPTH-1:0][7:0]    r_win;
    logic [POS_W-1:0]             r_pos;
    logic                         r_pend;
    logic [POS_W-1:0]             r_pend_off;
    logic [31:0]                  r_total;

    logic                         fire;
    logic [7:0]                   c;
    logic                         last;
    logic [WIN_DEPTH-1:0][7:0]    w_new;
    logic [WIN_DEPTH-1:0]         sp;
    logic [PATTERN_MAX-1:0]       eq;
    logic                         long_enough;
    logic [POS_W-1:0]             start;
    logic                         hit;
    logic                         emit_pend;
    logic                         emit_cur;
    t_out_item                    item_pend;
    t_out_item                    item_cur;

    assign fire       = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    assign c    = fold_case(r_in.char_code);
    assign last = r_in.sentence_end;

    always_comb begin
        w_new[0] = c;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            w_new[j] = r_win[j-1];
        end
        for (int j = 0; j < WIN_DEPTH; j++) begin
            sp[j] = (w_new[j] == SPACE_CODE);
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
            eq[j] = !i_pat.use_mask[j] || (w_new[j] == i_pat.chars[j]);
        end
    end

    assign long_enough = ((POS_W+1)'(r_pos) + (POS_W+1)'(1)) >= (POS_W+1)'(i_pat.len);
    assign start       = r_pos + POS_W'(1) - POS_W'(i_pat.len);

    // Leading boundary: sentence start or a space just before the match.
    assign hit = (i_pat.len != '0) && long_enough && (&eq)
                 && ((start == '0) || sp[i_pat.len[WIDX_W-1:0]]);

    // A held match is confirmed by a following space.
    assign emit_pend = r_pend && sp[0];
    assign emit_cur  = hit && last;

    always_comb begin
        item_pend.out_book      = r_in.in_book;
        item_pend.out_page      = r_in.in_page;
        item_pend.out_paragraph = r_in.in_paragraph;
        item_pend.out_sentence  = r_in.in_sentence;
        item_pend.start_offset  = r_pend_off;
        item_pend.match_total   = r_total + 32'd1;
        item_pend.last_of_run   = !emit_cur;

        item_cur.out_book       = r_in.in_book;
        item_cur.out_page       = r_in.in_page;
        item_cur.out_paragraph  = r_in.in_paragraph;
        item_cur.out_sentence   = r_in.in_sentence;
        item_cur.start_offset   = start;
        item_cur.match_total    = emit_pend ? r_total + 32'd2 : r_total + 32'd1;
        item_cur.last_of_run    = 1'b1;

        o_push.cnt    = fire ? {1'b0, emit_pend} + {1'b0, emit_cur} : 2'd0;
        o_push.first  = emit_pend ? item_pend : item_cur;
        o_push.second = item_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= {WIN_DEPTH{SPACE_CODE}};
            r_pos      <= '0;
            r_pend     <= 1'b0;
            r_pend_off <= '0;
            r_total    <= '0;
        end else if (fire) begin
            r_total    <= r_total + 32'(o_push.cnt);
            r_pend     <= hit && !last;
            r_pend_off <= start;
            if (last) begin
                r_win <= {WIN_DEPTH{SPACE_CODE}};
                r_pos <= '0;
            end else begin
                r_win <= w_new;
                if (r_pos < POS_LIMIT) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    `WW_ASSERT_NXT(a_end_clears, fire && last, (r_pos == '0) && !r_pend, "sentence end left state")
    `WW_ASSERT_IMP(a_two_only_at_end, o_push.cnt == 2'd2, last, "two results off sentence end")
    `WW_ASSERT_IMP(a_push_needs_fire, o_push.cnt != 2'd0, fire, "results pushed without a transaction")

endmodule

FILE: design/wwpm_outq.sv
// ----------------------------------------------------------------------------
// wwpm_outq
// Small result queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wwpm_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wwpm_pkg::t_push      i_push,
    output logic                 o_room,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wwpm_pkg::t_out_item  o_out_item
);
    import wwpm_pkg::*;

    t_out_item           r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;

    assign o_room      = r_count <= QCNT_W'(QDEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_item  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
        end
    end

    `WW_ASSERT(a_cnt_bound, r_count <= QCNT_W'(QDEPTH), "result queue overfilled")
    `WW_ASSERT_IMP(a_push_room, i_push.cnt != 2'd0, o_room, "push without room")

endmodule
